@@ src/pcwt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcwt_pkg
// Shared widths, codes and types for the polygon containment block.
// ----------------------------------------------------------------------------
package pcwt_pkg;

  localparam int MAX_VERTICES_DEF = 64;

  localparam int COORD_W  = 24;
  localparam int TOL_W    = 20;
  localparam int TOL2_W   = 2 * TOL_W;
  localparam int MODE_W   = 2;
  localparam int STATUS_W = 2;

  // datapath widths
  localparam int DIFF_W = COORD_W + 1;      // coordinate difference
  localparam int OP_W   = DIFF_W + 1;       // multiplier operand
  localparam int PROD_W = 2 * OP_W;         // multiplier product
  localparam int DIG_W  = 25;               // digit of a wide product
  localparam int PP_W   = 2 * DIG_W;        // partial product
  localparam int WIDE_W = 4 * DIG_W - 2;    // squared cross / scaled tolerance

  // input modes
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_APPEND = 2'd1;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_QUERY   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_UPDATED = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_DROPPED = 2'd2;

  // multiply sequencer steps, named by the product issued
  localparam int STEP_W = 5;
  localparam logic [STEP_W-1:0] ST_AP_XX = 5'd0;
  localparam logic [STEP_W-1:0] ST_AP_YY = 5'd1;
  localparam logic [STEP_W-1:0] ST_BP_XX = 5'd2;
  localparam logic [STEP_W-1:0] ST_BP_YY = 5'd3;
  localparam logic [STEP_W-1:0] ST_AB_XX = 5'd4;
  localparam logic [STEP_W-1:0] ST_AB_YY = 5'd5;
  localparam logic [STEP_W-1:0] ST_DOT_X = 5'd6;
  localparam logic [STEP_W-1:0] ST_DOT_Y = 5'd7;
  localparam logic [STEP_W-1:0] ST_CR_P  = 5'd8;
  localparam logic [STEP_W-1:0] ST_CR_N  = 5'd9;
  localparam logic [STEP_W-1:0] ST_LHS   = 5'd10;
  localparam logic [STEP_W-1:0] ST_RHS   = 5'd11;
  localparam logic [STEP_W-1:0] ST_C00   = 5'd12;
  localparam logic [STEP_W-1:0] ST_C01   = 5'd13;
  localparam logic [STEP_W-1:0] ST_C11   = 5'd14;
  localparam logic [STEP_W-1:0] ST_T0A0  = 5'd15;
  localparam logic [STEP_W-1:0] ST_T0A1  = 5'd16;
  localparam logic [STEP_W-1:0] ST_T1A0  = 5'd17;
  localparam logic [STEP_W-1:0] ST_T1A1  = 5'd18;
  localparam logic [STEP_W-1:0] ST_DRAIN = 5'd19;
  localparam logic [STEP_W-1:0] ST_DECIDE = 5'd20;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_LD,
    S_DIFF,
    S_MUL,
    S_OUT
  } state_t;

endpackage

@@ src/polygon_contains_with_tolerance.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polygon_contains_with_tolerance
// Even-odd point-in-polygon test with a squared-distance edge tolerance.
// ----------------------------------------------------------------------------
// Clear, append and a query on an empty store go from acceptance straight
// to the output state. A query over n vertices reads the store and runs
// each edge through a difference stage and 21 multiplier steps; each vertex
// read passes the read and load states, and the closing edge reads nothing.
// The next transaction is accepted only after the result is loaded.
// Synchronous reset empties the store and sets the tolerance to 102.
module polygon_contains_with_tolerance #(
  parameter int MAX_VERTICES = pcwt_pkg::MAX_VERTICES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [pcwt_pkg::MODE_W-1:0]       in_mode,
  input  logic signed [pcwt_pkg::COORD_W-1:0] in_coord_x,
  input  logic signed [pcwt_pkg::COORD_W-1:0] in_coord_y,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [pcwt_pkg::STATUS_W-1:0]     out_status,
  output logic                              out_inside_res,
  output logic                              out_near_edge,
  output logic                              out_hit,
  input  logic                              cfg_wr_en,
  input  logic [pcwt_pkg::TOL_W-1:0]        cfg_wr_data
);

  import pcwt_pkg::*;

  localparam int AW    = $clog2(MAX_VERTICES);
  localparam int CNT_W = $clog2(MAX_VERTICES + 1);
  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(102);

  state_t state_r, state_nxt;

  logic [CNT_W-1:0]          cnt_r;
  logic [CNT_W-1:0]          edge_r;
  logic [AW-1:0]             rd_addr_r;
  logic                      first_r;
  logic [TOL_W-1:0]          tol_r;
  logic [TOL2_W-1:0]         tol2_r;
  logic signed [COORD_W-1:0] px_r, py_r, ax_r, ay_r, bx_r, by_r, fx_r, fy_r;
  logic signed [DIFF_W-1:0]  apx_r, apy_r, bpx_r, bpy_r, abx_r, aby_r;
  logic [STEP_W-1:0]         step_r, tag_r;
  logic                      prod_v_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [PROD_W-1:0]  ap2_r, bp2_r, ab2_r, dot_r, cr_r, lhs_r, rhs_r;
  logic [WIDE_W-1:0]         csq_r, tsq_r;
  logic                      par_r, near_r;
  logic [STATUS_W-1:0]       res_status_r;

  logic                      out_valid_r;
  logic [STATUS_W-1:0]       out_status_r;
  logic                      out_inside_r, out_near_r;

  logic                      in_acc;
  logic                      is_query;
  logic                      room;
  logic                      ram_we;
  logic [COORD_W-1:0]        rx_data, ry_data;
  logic                      out_free;

  logic signed [OP_W-1:0]    op_a, op_b;
  logic signed [PROD_W-1:0]  mul_p;
  logic signed [PROD_W-1:0]  c_abs;
  logic [DIG_W-1:0]          c0, c1, a0, a1, t0, t1;
  logic [WIDE_W-1:0]         pw;
  logic signed [PROD_W-1:0]  tol2_e;
  logic                      near_e, strad, left_e;
  logic [CNT_W:0]            edge_p1, edge_p2;

  // handshake and store control
  always_comb begin
    in_ready = (state_r == S_IDLE);
    in_acc   = in_valid && in_ready;
    is_query = in_mode[1];
    room     = (cnt_r < CNT_W'(MAX_VERTICES));
    ram_we   = in_acc && (in_mode == MODE_APPEND) && room;
    out_free = !out_valid_r || out_ready;
  end

  pcwt_ram #(.WIDTH(COORD_W), .DEPTH(MAX_VERTICES)) u_ram_x (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_r[AW-1:0]),
    .wdata (in_coord_x),
    .raddr (rd_addr_r),
    .rdata (rx_data)
  );

  pcwt_ram #(.WIDTH(COORD_W), .DEPTH(MAX_VERTICES)) u_ram_y (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_r[AW-1:0]),
    .wdata (in_coord_y),
    .raddr (rd_addr_r),
    .rdata (ry_data)
  );

  assign edge_p1 = {1'b0, edge_r} + (CNT_W+1)'(1);
  assign edge_p2 = {1'b0, edge_r} + (CNT_W+1)'(2);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = (is_query && (cnt_r != '0)) ? S_RD : S_OUT;
        end
      end
      S_RD: state_nxt = S_LD;
      S_LD: begin
        if (first_r && (cnt_r != CNT_W'(1))) begin
          state_nxt = S_RD;
        end else begin
          state_nxt = S_DIFF;
        end
      end
      S_DIFF: state_nxt = S_MUL;
      S_MUL: begin
        if (step_r == ST_DECIDE) begin
          if (edge_p1 == {1'b0, cnt_r}) begin
            state_nxt = S_OUT;
          end else if (edge_p2 == {1'b0, cnt_r}) begin
            state_nxt = S_DIFF;
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // multiplier operand selection
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (step_r)
      ST_AP_XX: begin op_a = OP_W'(apx_r); op_b = OP_W'(apx_r); end
      ST_AP_YY: begin op_a = OP_W'(apy_r); op_b = OP_W'(apy_r); end
      ST_BP_XX: begin op_a = OP_W'(bpx_r); op_b = OP_W'(bpx_r); end
      ST_BP_YY: begin op_a = OP_W'(bpy_r); op_b = OP_W'(bpy_r); end
      ST_AB_XX: begin op_a = OP_W'(abx_r); op_b = OP_W'(abx_r); end
      ST_AB_YY: begin op_a = OP_W'(aby_r); op_b = OP_W'(aby_r); end
      ST_DOT_X: begin op_a = OP_W'(apx_r); op_b = OP_W'(abx_r); end
      ST_DOT_Y: begin op_a = OP_W'(apy_r); op_b = OP_W'(aby_r); end
      ST_CR_P:  begin op_a = OP_W'(apx_r); op_b = OP_W'(aby_r); end
      ST_CR_N:  begin op_a = OP_W'(apy_r); op_b = OP_W'(abx_r); end
      ST_LHS:   begin op_a = OP_W'(bpx_r); op_b = OP_W'(aby_r); end
      ST_RHS:   begin op_a = OP_W'(abx_r); op_b = OP_W'(bpy_r); end
      ST_C00:   begin op_a = $signed({1'b0, c0}); op_b = $signed({1'b0, c0}); end
      ST_C01:   begin op_a = $signed({1'b0, c0}); op_b = $signed({1'b0, c1}); end
      ST_C11:   begin op_a = $signed({1'b0, c1}); op_b = $signed({1'b0, c1}); end
      ST_T0A0:  begin op_a = $signed({1'b0, t0}); op_b = $signed({1'b0, a0}); end
      ST_T0A1:  begin op_a = $signed({1'b0, t0}); op_b = $signed({1'b0, a1}); end
      ST_T1A0:  begin op_a = $signed({1'b0, t1}); op_b = $signed({1'b0, a0}); end
      ST_T1A1:  begin op_a = $signed({1'b0, t1}); op_b = $signed({1'b0, a1}); end
      default: begin op_a = '0; op_b = '0; end
    endcase
  end

  assign mul_p = op_a * op_b;

  // digits of the wide operands
  always_comb begin
    c_abs  = cr_r[PROD_W-1] ? -cr_r : cr_r;
    c0     = c_abs[DIG_W-1:0];
    c1     = c_abs[2*DIG_W-1:DIG_W];
    a0     = ab2_r[DIG_W-1:0];
    a1     = ab2_r[2*DIG_W-1:DIG_W];
    t0     = tol2_r[DIG_W-1:0];
    t1     = DIG_W'(tol2_r[TOL2_W-1:DIG_W]);
    pw     = WIDE_W'(prod_r[PP_W-1:0]);
    tol2_e = $signed(PROD_W'(tol2_r));
  end

  // per-edge decision
  always_comb begin
    if ((ab2_r == '0) || dot_r[PROD_W-1] || (dot_r == '0)) begin
      near_e = (ap2_r <= tol2_e);
    end else if (dot_r >= ab2_r) begin
      near_e = (bp2_r <= tol2_e);
    end else begin
      near_e = (csq_r <= tsq_r);
    end
    strad  = (ay_r > py_r) != (by_r > py_r);
    left_e = aby_r[DIFF_W-1] ? (lhs_r > rhs_r) : (lhs_r < rhs_r);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      tol_r       <= TOL_RESET;
      out_valid_r <= 1'b0;
      prod_v_r    <= 1'b0;
      step_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        tol_r <= cfg_wr_data;
      end
      if (in_acc) begin
        if (in_mode == MODE_CLEAR) begin
          cnt_r <= '0;
        end else if (ram_we) begin
          cnt_r <= cnt_r + CNT_W'(1);
        end
      end
      prod_v_r <= (state_r == S_MUL) && (step_r <= ST_T1A1);
      if (state_r == S_DIFF) begin
        step_r <= ST_AP_XX;
      end else if (state_r == S_MUL) begin
        step_r <= step_r + STEP_W'(1);
      end
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    // take the transaction
    if (in_acc) begin
      px_r      <= in_coord_x;
      py_r      <= in_coord_y;
      tol2_r    <= TOL2_W'(tol_r) * TOL2_W'(tol_r);
      par_r     <= 1'b0;
      near_r    <= 1'b0;
      first_r   <= 1'b1;
      rd_addr_r <= '0;
      edge_r    <= '0;
      if (is_query) begin
        res_status_r <= STATUS_QUERY;
      end else if ((in_mode == MODE_APPEND) && !room) begin
        res_status_r <= STATUS_DROPPED;
      end else begin
        res_status_r <= STATUS_UPDATED;
      end
    end

    // capture vertex data
    if (state_r == S_LD) begin
      if (first_r) begin
        ax_r    <= rx_data;
        ay_r    <= ry_data;
        fx_r    <= rx_data;
        fy_r    <= ry_data;
        first_r <= 1'b0;
        if (cnt_r == CNT_W'(1)) begin
          bx_r <= rx_data;
          by_r <= ry_data;
        end else begin
          rd_addr_r <= AW'(1);
        end
      end else begin
        bx_r <= rx_data;
        by_r <= ry_data;
      end
    end

    // edge differences
    if (state_r == S_DIFF) begin
      apx_r <= {px_r[COORD_W-1], px_r} - {ax_r[COORD_W-1], ax_r};
      apy_r <= {py_r[COORD_W-1], py_r} - {ay_r[COORD_W-1], ay_r};
      bpx_r <= {px_r[COORD_W-1], px_r} - {bx_r[COORD_W-1], bx_r};
      bpy_r <= {py_r[COORD_W-1], py_r} - {by_r[COORD_W-1], by_r};
      abx_r <= {bx_r[COORD_W-1], bx_r} - {ax_r[COORD_W-1], ax_r};
      aby_r <= {by_r[COORD_W-1], by_r} - {ay_r[COORD_W-1], ay_r};
    end

    // issue a product
    if (state_r == S_MUL) begin
      prod_r <= mul_p;
      tag_r  <= step_r;
    end

    // accumulate the previous product
    if (prod_v_r) begin
      case (tag_r)
        ST_AP_XX: ap2_r <= prod_r;
        ST_AP_YY: ap2_r <= ap2_r + prod_r;
        ST_BP_XX: bp2_r <= prod_r;
        ST_BP_YY: bp2_r <= bp2_r + prod_r;
        ST_AB_XX: ab2_r <= prod_r;
        ST_AB_YY: ab2_r <= ab2_r + prod_r;
        ST_DOT_X: dot_r <= prod_r;
        ST_DOT_Y: dot_r <= dot_r + prod_r;
        ST_CR_P:  cr_r  <= prod_r;
        ST_CR_N:  cr_r  <= cr_r - prod_r;
        ST_LHS:   lhs_r <= prod_r;
        ST_RHS:   rhs_r <= prod_r;
        ST_C00:   csq_r <= pw;
        ST_C01:   csq_r <= csq_r + (pw << (DIG_W + 1));
        ST_C11:   csq_r <= csq_r + (pw << (2 * DIG_W));
        ST_T0A0:  tsq_r <= pw;
        ST_T0A1:  tsq_r <= tsq_r + (pw << DIG_W);
        ST_T1A0:  tsq_r <= tsq_r + (pw << DIG_W);
        ST_T1A1:  tsq_r <= tsq_r + (pw << (2 * DIG_W));
        default: ;
      endcase
    end

    // close the edge and advance
    if ((state_r == S_MUL) && (step_r == ST_DECIDE)) begin
      near_r <= near_r | near_e;
      par_r  <= par_r ^ (strad && left_e);
      ax_r   <= bx_r;
      ay_r   <= by_r;
      edge_r <= edge_r + CNT_W'(1);
      if (edge_p2 == {1'b0, cnt_r}) begin
        bx_r <= fx_r;
        by_r <= fy_r;
      end else begin
        rd_addr_r <= rd_addr_r + AW'(1);
      end
    end

    // load the output register
    if ((state_r == S_OUT) && out_free) begin
      out_status_r <= res_status_r;
      out_inside_r <= (res_status_r == STATUS_QUERY) && (cnt_r >= CNT_W'(3)) && par_r;
      out_near_r   <= (res_status_r == STATUS_QUERY) && near_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_inside_res = out_inside_r;
  assign out_near_edge  = out_near_r;
  assign out_hit        = out_inside_r | out_near_r;

endmodule

@@ src/pcwt_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcwt_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module pcwt_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/pcwt_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcwt_checker
// Port-level checks on the polygon containment block, bound to the top.
// ----------------------------------------------------------------------------
module pcwt_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [pcwt_pkg::STATUS_W-1:0] out_status,
  input logic                          out_inside_res,
  input logic                          out_near_edge,
  input logic                          out_hit
);

  import pcwt_pkg::*;

  // store updates carry no query flags
  a_upd_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != STATUS_QUERY))
      |-> (!out_inside_res && !out_near_edge && !out_hit))
    else $error("flags set on a store update");

  // combined answer follows its parts
  a_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == STATUS_QUERY))
      |-> (out_hit == (out_inside_res || out_near_edge)))
    else $error("hit does not match inside or near");

  // one transaction in flight: busy after acceptance
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("accepted a second transaction while busy");

  // hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_status)))
    else $error("stalled result dropped or changed");

endmodule

bind polygon_contains_with_tolerance pcwt_checker u_pcwt_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_status     (out_status),
  .out_inside_res (out_inside_res),
  .out_near_edge  (out_near_edge),
  .out_hit        (out_hit)
);

@@ dv/polygon_contains_with_tolerance_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polygon_contains_with_tolerance_test
// Self-checking bench for the polygon containment block: polygons are loaded
// through clear and append transactions and probed with query points. Every
// transaction is predicted by a behavioural model of the crossing test and
// the squared edge distance, and results are compared field by field.
// ----------------------------------------------------------------------------
module polygon_contains_with_tolerance_test;
  import pcwt_pkg::*;

  localparam int NVERT = 64;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int QUIET_CYCLES = 2000;
  localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;
  localparam logic [MODE_W-1:0] MODE_QUERY_ALT = 2'd3;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic inside_res;
    logic near_edge;
    logic hit;
  } answer_t;

  typedef struct {
    logic [MODE_W-1:0] mode;
    int x;
    int y;
    bit known;
    answer_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [MODE_W-1:0] in_mode = MODE_CLEAR;
  logic signed [COORD_W-1:0] in_coord_x = '0;
  logic signed [COORD_W-1:0] in_coord_y = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic out_inside_res, out_near_edge, out_hit;
  logic cfg_wr_en = 1'b0;
  logic [TOL_W-1:0] cfg_wr_data = '0;

  // model state
  longint poly_x[NVERT];
  longint poly_y[NVERT];
  int poly_count;
  longint tolerance;

  answer_t answers_due[$];
  int mismatches = 0;
  int transactions_in = 0;
  int answers_out = 0;
  int queries_sent = 0;
  int hits_seen = 0;
  int quiet = 0;
  bit in_idle_ok = 1'b1;
  bit out_idle_ok = 1'b1;

  polygon_contains_with_tolerance i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_mode(in_mode), .in_coord_x(in_coord_x), .in_coord_y(in_coord_y),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_status(out_status), .out_inside_res(out_inside_res),
    .out_near_edge(out_near_edge), .out_hit(out_hit),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // segment distance test on squared values; 128-bit for the interior foot
  function automatic bit near_segment(longint px, longint py, longint ax, longint ay,
                                      longint bx, longint by);
    longint abx, aby, apx, apy, ab2, dot, cr;
    logic [127:0] lhs, rhs;
    abx = bx - ax; aby = by - ay;
    apx = px - ax; apy = py - ay;
    ab2 = abx * abx + aby * aby;
    dot = apx * abx + apy * aby;
    if (ab2 == 0 || dot <= 0) return (apx * apx + apy * apy) <= tolerance * tolerance;
    if (dot >= ab2) return ((px - bx) * (px - bx) + (py - by) * (py - by))
                           <= tolerance * tolerance;
    cr = apx * aby - apy * abx;
    if (cr < 0) cr = -cr;
    lhs = 128'(cr) * 128'(cr);
    rhs = 128'(tolerance * tolerance) * 128'(ab2);
    return lhs <= rhs;
  endfunction

  function automatic answer_t polygon_answer(logic [MODE_W-1:0] mode, longint x, longint y);
    answer_t r;
    bit ins, nr;
    int j, k;
    longint d, lhs, rhs;
    r = '{status: STATUS_UPDATED, inside_res: 1'b0, near_edge: 1'b0, hit: 1'b0};
    if (mode == MODE_CLEAR) begin
      poly_count = 0;
    end else if (mode == MODE_APPEND) begin
      if (poly_count < NVERT) begin
        poly_x[poly_count] = x;
        poly_y[poly_count] = y;
        poly_count++;
      end else begin
        r.status = STATUS_DROPPED;
      end
    end else begin
      ins = 1'b0;
      nr = 1'b0;
      if (poly_count >= 3) begin
        j = poly_count - 1;
        for (int i = 0; i < poly_count; i++) begin
          if ((poly_y[i] > y) != (poly_y[j] > y)) begin
            d = poly_y[j] - poly_y[i];
            lhs = (x - poly_x[i]) * d;
            rhs = (poly_x[j] - poly_x[i]) * (y - poly_y[i]);
            if ((d > 0) ? (lhs < rhs) : (lhs > rhs)) ins = !ins;
          end
          j = i;
        end
      end
      for (int i = 0; i < poly_count; i++) begin
        k = (i + 1 < poly_count) ? i + 1 : 0;
        if (near_segment(x, y, poly_x[i], poly_y[i], poly_x[k], poly_y[k])) nr = 1'b1;
      end
      r.status = STATUS_QUERY;
      r.inside_res = ins;
      r.near_edge = nr;
      r.hit = ins | nr;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch on answer %0d: %s got %0d want %0d", answers_out, what, got, want);
    mismatches++;
  endtask

  // send one transaction and hold it until accepted; valid drops only on idling
  task automatic send_item(logic [MODE_W-1:0] mode, int x, int y);
    if (in_idle_ok && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while (in_idle_ok && $urandom_range(99) < 9) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_coord_x <= x[COORD_W-1:0];
    in_coord_y <= y[COORD_W-1:0];
    do @(posedge clk); while (!in_ready);
    answers_due.insert(answers_due.size(),
                       polygon_answer(mode, longint'(signed'(x[COORD_W-1:0])),
                                      longint'(signed'(y[COORD_W-1:0]))));
    transactions_in++;
    if (mode[1]) queries_sent++;
  endtask

  task automatic drain_and_set_tolerance(int tol);
    in_valid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= tol[TOL_W-1:0];
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tolerance = tol;
  endtask

  function automatic int rand_coord();
    return int'($urandom_range(32'hFFFFFF)) - 8388608;
  endfunction

  // result side: random stall and compare against the oldest expectation
  always @(posedge clk) begin
    answer_t want;
    if (out_valid && out_ready) begin
      answers_out++;
      if (answers_due.size() == 0) begin
        report_mismatch("unexpected answer, status", out_status, 0);
      end else begin
        want = answers_due.pop_front();
        if (out_status !== want.status) report_mismatch("status", out_status, want.status);
        if (out_inside_res !== want.inside_res)
          report_mismatch("inside_res", out_inside_res, want.inside_res);
        if (out_near_edge !== want.near_edge)
          report_mismatch("near_edge", out_near_edge, want.near_edge);
        if (out_hit !== want.hit) report_mismatch("hit", out_hit, want.hit);
        if (out_hit === 1'b1) hits_seen++;
      end
    end
    out_ready <= rst_n && !(out_idle_ok && $urandom_range(99) < 9);
  end

  // watchdog on cycles without any accepted transaction or taken answer
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    stim_row_t rows[$];
    int sx, sy, half, n, cx, cy, kind;
    answer_t got;

    // directed rows: answers typed in for updates and the empty-store query, other queries left to the model
    rows = '{
      '{MODE_QUERY, 0, 0, 1, '{STATUS_QUERY, 1'b0, 1'b0, 1'b0}},
      '{MODE_APPEND, 0, 0, 1, '{STATUS_UPDATED, 1'b0, 1'b0, 1'b0}},
      '{MODE_QUERY, 50, 50, 0, '0},
      '{MODE_QUERY, 200, 0, 0, '0},
      '{MODE_APPEND, 1000, 0, 1, '{STATUS_UPDATED, 1'b0, 1'b0, 1'b0}},
      '{MODE_QUERY, 500, 90, 0, '0},
      '{MODE_APPEND, 1000, 1000, 1, '{STATUS_UPDATED, 1'b0, 1'b0, 1'b0}},
      '{MODE_APPEND, 0, 1000, 1, '{STATUS_UPDATED, 1'b0, 1'b0, 1'b0}},
      '{MODE_QUERY, 500, 500, 0, '0},
      '{MODE_QUERY_ALT, 500, 0, 0, '0},
      '{MODE_QUERY, 2000, 500, 0, '0},
      '{MODE_QUERY, 1050, 1050, 0, '0},
      '{MODE_CLEAR, -1, -1, 1, '{STATUS_UPDATED, 1'b0, 1'b0, 1'b0}},
      '{MODE_APPEND, -8388608, -8388608, 1, '{STATUS_UPDATED, 1'b0, 1'b0, 1'b0}},
      '{MODE_APPEND, 8388607, -8388608, 1, '{STATUS_UPDATED, 1'b0, 1'b0, 1'b0}},
      '{MODE_APPEND, 8388607, 8388607, 1, '{STATUS_UPDATED, 1'b0, 1'b0, 1'b0}},
      '{MODE_APPEND, -8388608, 8388607, 1, '{STATUS_UPDATED, 1'b0, 1'b0, 1'b0}},
      '{MODE_QUERY, 0, 0, 0, '0},
      '{MODE_QUERY, 8388607, 0, 0, '0},
      '{MODE_QUERY, -8388608, 8388607, 0, '0},
      '{MODE_CLEAR, 0, 0, 1, '{STATUS_UPDATED, 1'b0, 1'b0, 1'b0}}
    };
    tolerance = 102;
    poly_count = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[r]) begin
      send_item(rows[r].mode, rows[r].x, rows[r].y);
      got = answers_due[$];
      if (rows[r].known && got != rows[r].want)
        report_mismatch("directed row", r, got);
    end

    // fill past capacity: the last appends are dropped
    for (int i = 0; i < NVERT + 3; i++)
      send_item(MODE_APPEND, (i % 2) ? 4000 : -4000, i * 100);
    send_item(MODE_QUERY, 0, 3000);
    send_item(MODE_QUERY, 4000, 50);

    // the pause: wait until every answer has come, then change the tolerance
    drain_and_set_tolerance(0);
    send_item(MODE_QUERY, -4000, 0);
    drain_and_set_tolerance(20'hFFFFF);
    send_item(MODE_QUERY, 0, 3000);
    drain_and_set_tolerance(102);

    // random polygons: mostly small polygons of random vertices around a centre, some noise
    while (transactions_in < 1150) begin
      if (transactions_in > 400 && transactions_in < 700) begin
        in_idle_ok = 1'b0;
        out_idle_ok = 1'b0;
      end else begin
        in_idle_ok = 1'b1;
        out_idle_ok = 1'b1;
      end
      if ($urandom_range(9) == 0) begin
        case ($urandom_range(3))
          0: drain_and_set_tolerance($urandom_range(20'hFFFFF));
          1: drain_and_set_tolerance($urandom_range(2000));
          2: drain_and_set_tolerance(0);
          default: drain_and_set_tolerance($urandom_range(200));
        endcase
      end
      kind = $urandom_range(9);
      half = (kind == 0) ? 8000000 : $urandom_range(5000, 20);
      cx = $urandom_range(2 * (8388607 - half)) - (8388607 - half);
      cy = $urandom_range(2 * (8388607 - half)) - (8388607 - half);
      n = (kind == 1) ? $urandom_range(2) : $urandom_range(8, 3);
      if (kind == 2) n = $urandom_range(NVERT + 2, NVERT - 2);
      send_item(MODE_CLEAR, rand_coord(), rand_coord());
      for (int i = 0; i < n; i++) begin
        sx = cx + int'($urandom_range(2 * half)) - half;
        sy = cy + int'($urandom_range(2 * half)) - half;
        if (kind == 3 && i > 0) sy = cy;
        send_item(MODE_APPEND, sx, sy);
      end
      repeat ($urandom_range(6, 2)) begin
        if ($urandom_range(9) == 0) begin
          sx = rand_coord();
          sy = rand_coord();
        end else begin
          sx = cx + int'($urandom_range(2 * half + 400)) - half - 200;
          sy = cy + int'($urandom_range(2 * half + 400)) - half - 200;
        end
        send_item($urandom_range(1) ? MODE_QUERY : MODE_QUERY_ALT, sx, sy);
      end
    end

    in_valid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
    $display("covered %0d transactions, %0d queries, %0d hits", transactions_in,
             queries_sent, hits_seen);
    $display("polygons up to full store, drops, extremes and tolerance 0 to max");
    if (mismatches == 0 && answers_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
